// ----- hdl/ssm_pkg.sv -----
// shared types and constants for the sparse set key value map
// no dependencies; imported by ssm_front, ssm_back and the top level
package ssm_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int KEY_W    = 8;
  localparam int CNT_W    = IDX_W + 1;
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    OP_PUT    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_GET    = 3'd3,
    OP_ITH    = 3'd4,
    OP_NOP    = 3'd5
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } back_state_t;

  typedef struct packed {
    op_t                      op;
    logic [KEY_W-1:0]         key;
    logic signed [DATA_W-1:0] data;
    logic [KEY_W-1:0]         pos;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [KEY_W-1:0]         key_out;
    logic                     present;
    logic [CNT_W-1:0]         count_out;
    logic                     error;
  } result_t;

endpackage

// ----- hdl/ssm_front.sv -----
// front end: decodes incoming beats and holds them in a two-entry queue
// depends on ssm_pkg
module ssm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_func,
  input  logic [7:0]       in_key,
  input  logic [31:0]      in_data,
  input  logic [7:0]       in_pos,
  output logic             q_valid,
  output ssm_pkg::item_t   q_item,
  input  logic             q_pop
);
  import ssm_pkg::*;

  item_t      q_mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] q_cnt_r;
  item_t      dec;
  logic       push;

  always_comb begin
    dec.key  = in_key;
    dec.data = in_data;
    dec.pos  = in_pos;
    case (in_func)
      OP_PUT:    dec.op = OP_PUT;
      OP_REMOVE: dec.op = OP_REMOVE;
      OP_CLEAR:  dec.op = OP_CLEAR;
      OP_GET:    dec.op = OP_GET;
      OP_ITH:    dec.op = OP_ITH;
      default:   dec.op = OP_NOP;
    endcase
  end

  assign in_ready = (q_cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (q_cnt_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ----- hdl/ssm_back.sv -----
// back end: key store memories, valid bits, entry count and result register
// depends on ssm_pkg
module ssm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  ssm_pkg::item_t   q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output ssm_pkg::result_t out_res
);
  import ssm_pkg::*;

  back_state_t state_r, state_nxt;
  item_t       cur_r;
  logic [CAPACITY-1:0] valid_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r;
  result_t             out_res_r, res;

  logic [IDX_W-1:0]  slot_mem  [CAPACITY];
  logic [KEY_W-1:0]  dense_mem [CAPACITY];
  logic [DATA_W-1:0] val_mem   [CAPACITY];

  logic [IDX_W-1:0]  slot_rd, dense_raddr;
  logic [KEY_W-1:0]  dense_rd;
  logic [DATA_W-1:0] val_rd;
  logic [CNT_W-1:0]  cnt_m1;

  logic              slot_we, dense_we, val_we;
  logic [IDX_W-1:0]  slot_waddr, dense_waddr, val_waddr;
  logic [IDX_W-1:0]  slot_wdata;
  logic [KEY_W-1:0]  dense_wdata;
  logic              hit, set_bit, clr_bit, clr_all;

  assign cnt_m1      = count_r - 1'b1;
  assign dense_raddr = (q_item.op == OP_ITH) ? q_item.pos[IDX_W-1:0] : cnt_m1[IDX_W-1:0];

  always_ff @(posedge clk) begin
    slot_rd  <= slot_mem[q_item.key[IDX_W-1:0]];
    dense_rd <= dense_mem[dense_raddr];
    val_rd   <= val_mem[q_item.key[IDX_W-1:0]];
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (dense_we) dense_mem[dense_waddr] <= dense_wdata;
    if (val_we) val_mem[val_waddr] <= cur_r.data;
  end

  assign hit = valid_r[cur_r.key[IDX_W-1:0]];

  always_comb begin
    state_nxt   = state_r;
    q_pop       = 1'b0;
    count_nxt   = count_r;
    slot_we     = 1'b0;
    dense_we    = 1'b0;
    val_we      = 1'b0;
    slot_waddr  = cur_r.key[IDX_W-1:0];
    slot_wdata  = count_r[IDX_W-1:0];
    dense_waddr = count_r[IDX_W-1:0];
    dense_wdata = cur_r.key;
    val_waddr   = cur_r.key[IDX_W-1:0];
    set_bit     = 1'b0;
    clr_bit     = 1'b0;
    clr_all     = 1'b0;
    res         = '0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && (!out_valid_r || out_ready)) begin
          q_pop     = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        case (cur_r.op)
          OP_PUT: begin
            val_we      = 1'b1;
            res.present = hit;
            if (!hit) begin
              slot_we   = 1'b1;
              dense_we  = 1'b1;
              set_bit   = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          OP_REMOVE: begin
            if (hit) begin
              res.present  = 1'b1;
              res.data_out = val_rd;
              dense_we     = 1'b1;
              dense_waddr  = slot_rd;
              dense_wdata  = dense_rd;
              slot_we      = 1'b1;
              slot_waddr   = dense_rd[IDX_W-1:0];
              slot_wdata   = slot_rd;
              clr_bit      = 1'b1;
              count_nxt    = cnt_m1;
            end else begin
              res.error = 1'b1;
            end
          end
          OP_CLEAR: begin
            clr_all   = 1'b1;
            count_nxt = '0;
          end
          OP_GET: begin
            res.present  = hit;
            res.data_out = hit ? val_rd : '0;
          end
          OP_ITH: begin
            if ({1'b0, cur_r.pos} < count_r) res.key_out = dense_rd;
            else res.error = 1'b1;
          end
          default: ;
        endcase
        res.count_out = count_nxt;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_item;
    if (state_r == ST_EXEC) out_res_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (clr_all) valid_r <= '0;
      else if (set_bit) valid_r[cur_r.key[IDX_W-1:0]] <= 1'b1;
      else if (clr_bit) valid_r[cur_r.key[IDX_W-1:0]] <= 1'b0;
      if (state_r == ST_EXEC) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY)) else $error("entry count above capacity");

  a_exec_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |-> !out_valid_r) else $error("result register busy at execute");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && cur_r.op == OP_REMOVE && hit) |=> count_r == $past(count_r) - 1'b1)
    else $error("remove did not decrement count");

  a_put_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && cur_r.op == OP_PUT && !hit) |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not increment count");

endmodule

// ----- hdl/sparse_set_key_value_map.sv -----
// top level of the sparse set key value map
// depends on ssm_pkg, ssm_front and ssm_back
//
// usage:
//   in_* channel: one beat per operation; in_tuser carries the function code
//   (put, remove, clear, get, read i-th key), in_tdata the key, value, position
//   out_* channel: exactly one result beat per operation, in order
//   a beat is accepted when tvalid and tready are both high
//   an accepted beat passes the queue and the execute state into the result
//   register; the key memories are read into registers as an operation leaves
//   the queue and written back in the execute state, one operation at a time
//   a two-entry queue lets the input keep accepting while a result waits
//   reset (rst_n low, synchronous) empties the queue, drops all keys at once
//   and zeroes the entry count; memory contents are not touched
//   when the receiver stalls the result holds in the output register, the
//   queue fills and then in_tready drops
module sparse_set_key_value_map (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // key[7:0], data_in[39:8], position[47:40]
  input  logic [2:0]  in_tuser,   // func[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // data_out[31:0], key_out[39:32], present[40],
                                  // count_out[49:41], error[50], zero[55:51]
);
  import ssm_pkg::*;

  logic    q_valid, q_pop;
  item_t   q_item;
  result_t res;

  // decode and buffer incoming beats
  ssm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_func  (in_tuser),
    .in_key   (in_tdata[7:0]),
    .in_data  (in_tdata[39:8]),
    .in_pos   (in_tdata[47:40]),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // execute against the sparse set storage
  ssm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // pack result fields, lowest first
  assign out_tdata = {5'd0, res.error, res.count_out, res.present, res.key_out, res.data_out};

endmodule

// ----- tb/sv/ssm_checker.sv -----
// scoreboard for the sparse set key value map: watches both stream channels,
// keeps its own copy of the map and compares every result beat
// depends on ssm_pkg
`timescale 1ns / 1ps

module ssm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  output int          fail_count,
  output int          pending
);
  import ssm_pkg::*;

  logic             map_valid [CAPACITY];
  logic [IDX_W-1:0] map_slot  [CAPACITY];
  logic [KEY_W-1:0] map_dense [CAPACITY];
  logic [31:0]      map_value [CAPACITY];
  logic [CNT_W-1:0] map_count;
  result_t          expected_results[$];

  function automatic result_t apply_op(logic [2:0] fn, logic [7:0] k, logic [31:0] v,
                                       logic [7:0] p);
    result_t r;
    logic [IDX_W-1:0] hole;
    logic [KEY_W-1:0] last;
    r = '0;
    case (fn)
      OP_PUT: begin
        if (map_valid[k]) begin
          r.present = 1'b1;
        end else begin
          map_dense[map_count[IDX_W-1:0]] = k;
          map_slot[k] = map_count[IDX_W-1:0];
          map_valid[k] = 1'b1;
          map_count++;
        end
        map_value[k] = v;
      end
      OP_REMOVE: begin
        if (map_valid[k] && map_count != 0) begin
          hole = map_slot[k];
          last = map_dense[IDX_W'(map_count - 1'b1)];
          r.present = 1'b1;
          map_dense[hole] = last;
          map_slot[last] = hole;
          map_count--;
          map_valid[k] = 1'b0;
          r.data_out = map_value[k];
        end else begin
          r.error = 1'b1;
        end
      end
      OP_CLEAR: begin
        foreach (map_valid[i]) map_valid[i] = 1'b0;
        map_count = '0;
      end
      OP_GET: begin
        if (map_valid[k]) begin
          r.present = 1'b1;
          r.data_out = map_value[k];
        end
      end
      OP_ITH: begin
        if (p < map_count) r.key_out = map_dense[p];
        else r.error = 1'b1;
      end
      default: ;
    endcase
    r.count_out = map_count;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      foreach (map_valid[i]) map_valid[i] = 1'b0;
      map_count = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_op(in_tuser, in_tdata[7:0], in_tdata[39:8],
                                            in_tdata[47:40]));
      if (out_tvalid && out_tready) begin
        got.data_out  = out_tdata[31:0];
        got.key_out   = out_tdata[39:32];
        got.present   = out_tdata[40];
        got.count_out = out_tdata[49:41];
        got.error     = out_tdata[50];
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %h", out_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got !== want || out_tdata[55:51] !== 5'd0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: data %h/%h key %h/%h pres %b/%b cnt %0d/%0d err %b/%b",
                       want.data_out, got.data_out, want.key_out, got.key_out,
                       want.present, got.present, want.count_out, got.count_out,
                       want.error, got.error);
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- tb/sv/sparse_set_key_value_map_tb.sv -----
// stimulus and verdict for the sparse set key value map
// depends on ssm_pkg, ssm_checker and the block itself
`timescale 1ns / 1ps

module sparse_set_key_value_map_tb;
  import ssm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // key[7:0], data_in[39:8], position[47:40]
  logic [2:0]  in_tuser;   // func[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // data_out, key_out, present, count_out, error, zero
  int          fail_count;
  int          pending;
  int          idle_cycles;
  bit          drain_stalls;

  sparse_set_key_value_map uut (.*);

  ssm_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // drives one beat, holding it until accepted; valid drops only for a gap
  task automatic send_op(op_t fn, logic [7:0] k, logic [31:0] v, logic [7:0] p);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {p, v, k};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // a key from a small pool most of the time so puts and removes collide
  function automatic logic [7:0] pick_key();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 23));
    return 8'($urandom_range(0, 255));
  endfunction

  // receiver stalls of random length, now and then a long one; none while draining
  initial begin
    int g;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (drain_stalls) begin
        out_tready <= 1'b1;
      end else begin
        g = gap_len();
        if (g == 0) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
  end

  // stall watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sparse_set_key_value_map test failed");
      $finish;
    end
  end

  initial begin
    int r;
    int p;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_PUT;
    drain_stalls = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty map cases, extremes, every code
    send_op(OP_GET, 8'd0, 32'd0, 8'd0);
    send_op(OP_REMOVE, 8'd5, 32'd0, 8'd0);
    send_op(OP_ITH, 8'd0, 32'd0, 8'd0);
    send_op(OP_PUT, 8'd0, 32'h8000_0000, 8'hff);
    send_op(OP_PUT, 8'd255, 32'h7fff_ffff, 8'd0);
    send_op(OP_PUT, 8'd85, 32'hffff_ffff, 8'd0);
    send_op(OP_PUT, 8'd0, 32'h0000_0000, 8'd0);
    send_op(OP_GET, 8'd0, 32'd0, 8'd0);
    send_op(OP_GET, 8'd255, 32'd0, 8'd0);
    send_op(OP_ITH, 8'd0, 32'd0, 8'd2);
    send_op(OP_ITH, 8'd0, 32'd0, 8'd3);
    send_op(OP_ITH, 8'd0, 32'd0, 8'd255);
    send_op(OP_REMOVE, 8'd0, 32'd0, 8'd0);
    send_op(OP_ITH, 8'd0, 32'd0, 8'd0);
    send_op(OP_REMOVE, 8'd170, 32'd0, 8'd0);
    send_op(op_t'(3'd5), 8'hff, 32'hffff_ffff, 8'hff);
    send_op(op_t'(3'd6), 8'd0, 32'd0, 8'd0);
    send_op(op_t'(3'd7), 8'd1, 32'd1, 8'd1);
    send_op(OP_CLEAR, 8'd0, 32'd0, 8'd0);
    send_op(OP_GET, 8'd255, 32'd0, 8'd0);
    send_op(OP_ITH, 8'd0, 32'd0, 8'd0);

    // fill the whole key space so the count reaches its top
    for (int k = 0; k < 256; k++) send_op(OP_PUT, k[7:0], $urandom, 8'd0);
    send_op(OP_PUT, 8'd77, $urandom, 8'd0);
    send_op(OP_ITH, 8'd0, 32'd0, 8'd255);
    in_tvalid <= 1'b0;

    // hold off until every expected result is back
    wait (pending == 0);
    repeat (5) @(negedge clk);

    for (int n = 0; n < 1350; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_op(OP_PUT, pick_key(), $urandom, 8'($urandom));
      end else if (r < 55) begin
        send_op(OP_REMOVE, pick_key(), $urandom, 8'($urandom));
      end else if (r < 75) begin
        send_op(OP_GET, pick_key(), $urandom, 8'($urandom));
      end else if (r < 93) begin
        p = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 30);
        send_op(OP_ITH, 8'($urandom), $urandom, p[7:0]);
      end else if (r < 95) begin
        send_op(OP_CLEAR, 8'($urandom), $urandom, 8'($urandom));
      end else begin
        send_op(op_t'($urandom_range(5, 7)), 8'($urandom), $urandom, 8'($urandom));
      end
    end
    in_tvalid <= 1'b0;

    drain_stalls = 1'b1;
    wait (pending == 0);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("sparse_set_key_value_map test passed");
    end else begin
      $display("sparse_set_key_value_map test failed");
    end
    $finish;
  end

endmodule
